FILE: sv/sorm_pkg.sv
// ----------------------------------------------------------------------------
// sorm_pkg: shared definitions for the six-axis over-range monitor
// Field widths, register indexes and counter constants.
// ----------------------------------------------------------------------------
package sorm_pkg;

  // Width of every sample and clamped result port
  localparam int FIELD_WIDTH = 32;
  // Number of low bits of each sample port that carry the sample
  localparam int SAMPLE_WIDTH = 32;
  // Sample widened by one bit so that its magnitude and negated limit fit
  localparam int EXT_WIDTH = FIELD_WIDTH + 1;
  // Q27 threshold and limit registers
  localparam int Q27_WIDTH = 31;
  // Leaky event counter
  localparam int COUNT_WIDTH = 16;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 32;

  typedef logic signed [FIELD_WIDTH-1:0] field_t;
  typedef logic signed [EXT_WIDTH-1:0] ext_t;
  typedef logic [Q27_WIDTH-1:0] q27_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
  typedef logic [CFG_DATA_WIDTH-1:0] cfg_data_t;

  // Register indexes
  localparam cfg_index_t REG_ACCEL_THRESHOLD = 3'd0;
  localparam cfg_index_t REG_RATE_THRESHOLD = 3'd1;
  localparam cfg_index_t REG_ACCEL_LIMIT = 3'd2;
  localparam cfg_index_t REG_RATE_LIMIT = 3'd3;
  localparam cfg_index_t REG_COUNT_LIMIT = 3'd4;
  localparam cfg_index_t REG_RESTART_ENABLE = 3'd5;

endpackage

FILE: sv/sensor_over_range_monitor.sv
// ----------------------------------------------------------------------------
// sensor_over_range_monitor: six-axis over-range monitor
// Clamps each axis of an inertial sample and keeps a leaky over-range counter.
// ----------------------------------------------------------------------------
// Usage
//   Samples enter on the in channel (in_valid/in_ready), three accelerations
//   and three angular rates, signed Q27 in the low SAMPLE_WIDTH bits of each
//   port. One result per sample leaves on the out channel (out_valid/
//   out_ready): the six clamped axes, the per-sample over-range flag, the
//   sticky status and the restart pulse.
//   The cfg channel writes the threshold, limit and restart registers; it is
//   always ready and is to be used only while no sample is in flight.
//   A sample is captured in the input register at the edge of its
//   transaction and moves to the output register once that is free.
//   Throughput: one sample per cycle unless the receiver stalls; the counter
//   update, the six compares and the clamps sit between the two registers.
//   Reset clears both registers' valid flags, the counter and the status, and
//   loads the register reset values. When the receiver stalls, the output
//   holds and the input register takes one more sample only if it is empty;
//   then in_ready drops.
// ----------------------------------------------------------------------------
module sensor_over_range_monitor (
  input  logic                    clk,
  input  logic                    rst,
  // sample channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  sorm_pkg::field_t        accel_x,
  input  sorm_pkg::field_t        accel_y,
  input  sorm_pkg::field_t        accel_z,
  input  sorm_pkg::field_t        rate_x,
  input  sorm_pkg::field_t        rate_y,
  input  sorm_pkg::field_t        rate_z,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output sorm_pkg::field_t        clamped_accel_x,
  output sorm_pkg::field_t        clamped_accel_y,
  output sorm_pkg::field_t        clamped_accel_z,
  output sorm_pkg::field_t        clamped_rate_x,
  output sorm_pkg::field_t        clamped_rate_y,
  output sorm_pkg::field_t        clamped_rate_z,
  output logic                    sample_over_range,
  output logic                    over_range_status,
  output logic                    restart_request,
  // configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  sorm_pkg::cfg_index_t    cfg_index,
  input  sorm_pkg::cfg_data_t     cfg_data
);
  import sorm_pkg::*;

  // Read a sample from the low bits of its port and widen it
  function automatic ext_t widen(field_t raw);
    logic signed [SAMPLE_WIDTH-1:0] s;
    s = raw[SAMPLE_WIDTH-1:0];
    return EXT_WIDTH'(s);
  endfunction

  // Magnitude strictly above threshold
  function automatic logic over_thr(ext_t x, q27_t thr);
    ext_t mag;
    mag = x[EXT_WIDTH-1] ? -x : x;
    return mag > signed'(EXT_WIDTH'(thr));
  endfunction

  // Clamp to plus or minus limit
  function automatic field_t clamp(ext_t x, q27_t lim);
    ext_t l;
    ext_t r;
    l = signed'(EXT_WIDTH'(lim));
    if (x > l) begin
      r = l;
    end else if (x < -l) begin
      r = -l;
    end else begin
      r = x;
    end
    return r[FIELD_WIDTH-1:0];
  endfunction

  // Configuration registers
  q27_t   accel_thr;
  q27_t   rate_thr;
  q27_t   accel_lim;
  q27_t   rate_lim;
  count_t count_limit;
  logic   restart_en;

  // State
  count_t event_count;
  logic   status_flag;
  count_t event_count_next;
  logic   status_flag_next;

  // Input register
  logic   s1_valid;
  ext_t   s1_axis [6];

  // Datapath signals
  logic [5:0] hit;
  logic [2:0] hit_count;
  logic [COUNT_WIDTH:0] bumped_sum;
  count_t bumped;
  logic   restart_now;
  field_t clamped [6];
  logic   out_load;
  logic   s1_load;

  assign cfg_ready = 1'b1;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_thr <= '1;
      rate_thr <= '1;
      accel_lim <= '1;
      rate_lim <= '1;
      count_limit <= COUNT_MAX;
      restart_en <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACCEL_THRESHOLD: accel_thr <= cfg_data[Q27_WIDTH-1:0];
        REG_RATE_THRESHOLD:  rate_thr <= cfg_data[Q27_WIDTH-1:0];
        REG_ACCEL_LIMIT:     accel_lim <= cfg_data[Q27_WIDTH-1:0];
        REG_RATE_LIMIT:      rate_lim <= cfg_data[Q27_WIDTH-1:0];
        REG_COUNT_LIMIT:     count_limit <= cfg_data[COUNT_WIDTH-1:0];
        REG_RESTART_ENABLE:  restart_en <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Advance when the output register is free or being emptied
  assign out_load = s1_valid && (!out_valid || out_ready);
  assign s1_load = in_valid && in_ready;
  assign in_ready = !s1_valid || out_load;

  // Capture the sample
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_axis[0] <= widen(accel_x);
      s1_axis[1] <= widen(accel_y);
      s1_axis[2] <= widen(accel_z);
      s1_axis[3] <= widen(rate_x);
      s1_axis[4] <= widen(rate_y);
      s1_axis[5] <= widen(rate_z);
    end
  end

  // Compare and clamp each axis against its group's registers
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hit[i] = over_thr(s1_axis[i], accel_thr);
      clamped[i] = clamp(s1_axis[i], accel_lim);
    end
    for (int i = 3; i < 6; i++) begin
      hit[i] = over_thr(s1_axis[i], rate_thr);
      clamped[i] = clamp(s1_axis[i], rate_lim);
    end
  end

  // Add two per hit with saturation, then restart, leak or clear status
  always_comb begin
    hit_count = 3'($countones(hit));
    bumped_sum = {1'b0, event_count} + (COUNT_WIDTH + 1)'({hit_count, 1'b0});
    bumped = bumped_sum[COUNT_WIDTH] ? COUNT_MAX : bumped_sum[COUNT_WIDTH-1:0];
    restart_now = 1'b0;
    status_flag_next = status_flag || (hit != '0);
    if (bumped > count_limit && restart_en) begin
      event_count_next = '0;
      restart_now = 1'b1;
    end else if (bumped != '0) begin
      event_count_next = bumped - count_t'(1);
    end else begin
      event_count_next = bumped;
      status_flag_next = 1'b0;
    end
  end

  // Update state as each sample passes to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_count <= '0;
      status_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        event_count <= event_count_next;
        status_flag <= status_flag_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (out_load) begin
      clamped_accel_x <= clamped[0];
      clamped_accel_y <= clamped[1];
      clamped_accel_z <= clamped[2];
      clamped_rate_x <= clamped[3];
      clamped_rate_y <= clamped[4];
      clamped_rate_z <= clamped[5];
      sample_over_range <= (hit != '0);
      over_range_status <= status_flag_next;
      restart_request <= restart_now;
    end
  end

endmodule

FILE: sv/sorm_checker.sv
// ----------------------------------------------------------------------------
// sorm_checker: port-level checks for the over-range monitor
// Watches the result channel and the status flags over time.
// ----------------------------------------------------------------------------
module sorm_checker (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input sorm_pkg::field_t clamped_accel_x,
  input logic             sample_over_range,
  input logic             over_range_status,
  input logic             restart_request
);
  import sorm_pkg::*;

  // A hit in this sample leaves the status set
  a_hit_sets_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_over_range |-> over_range_status)
    else $error("over-range sample without status set");

  // A restart only fires while the counter, and so the status, is live
  a_restart_with_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && restart_request |-> over_range_status)
    else $error("restart request with status clear");

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays offered
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_stall_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(clamped_accel_x) && $stable(restart_request)
      && $stable(over_range_status))
    else $error("result changed while stalled");

endmodule

bind sensor_over_range_monitor sorm_checker u_sorm_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .clamped_accel_x   (clamped_accel_x),
  .sample_over_range (sample_over_range),
  .over_range_status (over_range_status),
  .restart_request   (restart_request)
);

FILE: test/over_range_checker.sv
// ----------------------------------------------------------------------------
// over_range_checker: result checking for the six-axis over-range monitor
// Watches the sample, result and configuration channels. Keeps its own copy
// of the registers, the event counter and the sticky status, works out the
// result of every accepted sample and compares each result transaction with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module over_range_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  sorm_pkg::field_t     accel_x,
  input  sorm_pkg::field_t     accel_y,
  input  sorm_pkg::field_t     accel_z,
  input  sorm_pkg::field_t     rate_x,
  input  sorm_pkg::field_t     rate_y,
  input  sorm_pkg::field_t     rate_z,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  sorm_pkg::field_t     clamped_accel_x,
  input  sorm_pkg::field_t     clamped_accel_y,
  input  sorm_pkg::field_t     clamped_accel_z,
  input  sorm_pkg::field_t     clamped_rate_x,
  input  sorm_pkg::field_t     clamped_rate_y,
  input  sorm_pkg::field_t     clamped_rate_z,
  input  logic                 sample_over_range,
  input  logic                 over_range_status,
  input  logic                 restart_request,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  sorm_pkg::cfg_index_t cfg_index,
  input  sorm_pkg::cfg_data_t  cfg_data,
  output int                   mismatches,
  output int                   results_due,
  output int                   restarts_seen
);
  import sorm_pkg::*;

  localparam int EVENT_STEP = 2;

  typedef struct packed {
    field_t ax;
    field_t ay;
    field_t az;
    field_t rx;
    field_t ry;
    field_t rz;
    logic   over;
    logic   status;
    logic   restart;
  } monitor_result_t;

  // Register copies
  q27_t   accel_thr;
  q27_t   rate_thr;
  q27_t   accel_lim;
  q27_t   rate_lim;
  count_t count_lim;
  logic   restart_en;

  // Block state as predicted
  count_t events;
  logic   sticky;
  logic   sample_hit;

  monitor_result_t clamped_due[$];
  monitor_result_t want;

  // Check one axis against its threshold, bump the counter, clamp it
  function automatic field_t clamp_axis(input field_t raw, input q27_t thr, input q27_t lim);
    logic signed [SAMPLE_WIDTH-1:0] narrow;
    ext_t                           x;
    ext_t                           mag;
    ext_t                           thr_e;
    ext_t                           lim_e;
    logic [COUNT_WIDTH:0]           bumped;
    narrow = raw[SAMPLE_WIDTH-1:0];
    x = EXT_WIDTH'(narrow);
    mag = (x < 0) ? -x : x;
    thr_e = {2'b00, thr};
    lim_e = {2'b00, lim};
    if (mag > thr_e) begin
      bumped = {1'b0, events} + (COUNT_WIDTH + 1)'(EVENT_STEP);
      events = (bumped > COUNT_MAX) ? COUNT_MAX : bumped[COUNT_WIDTH-1:0];
      sticky = 1'b1;
      sample_hit = 1'b1;
    end
    if (x > lim_e) begin
      x = lim_e;
    end else if (x < -lim_e) begin
      x = -lim_e;
    end
    return x[FIELD_WIDTH-1:0];
  endfunction

  // Clamp all six axes, then leak, restart or clear
  function automatic monitor_result_t clamp_and_count(
    input field_t ax, input field_t ay, input field_t az,
    input field_t rx, input field_t ry, input field_t rz
  );
    monitor_result_t r;
    sample_hit = 1'b0;
    r.ax = clamp_axis(ax, accel_thr, accel_lim);
    r.ay = clamp_axis(ay, accel_thr, accel_lim);
    r.az = clamp_axis(az, accel_thr, accel_lim);
    r.rx = clamp_axis(rx, rate_thr, rate_lim);
    r.ry = clamp_axis(ry, rate_thr, rate_lim);
    r.rz = clamp_axis(rz, rate_thr, rate_lim);
    r.restart = 1'b0;
    if (events > count_lim && restart_en) begin
      events = '0;
      r.restart = 1'b1;
    end else if (events != '0) begin
      events = events - 1'b1;
    end else begin
      sticky = 1'b0;
    end
    r.over = sample_hit;
    r.status = sticky;
    return r;
  endfunction

  task automatic compare_field(input string what, input field_t exp_val, input field_t act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      accel_thr = '1;
      rate_thr = '1;
      accel_lim = '1;
      rate_lim = '1;
      count_lim = '1;
      restart_en = 1'b0;
      events = '0;
      sticky = 1'b0;
      clamped_due.delete();
      mismatches = 0;
      restarts_seen = 0;
    end else begin
      // Track register writes; unmapped indexes and spare bits drop out
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACCEL_THRESHOLD: accel_thr = cfg_data[Q27_WIDTH-1:0];
          REG_RATE_THRESHOLD:  rate_thr = cfg_data[Q27_WIDTH-1:0];
          REG_ACCEL_LIMIT:     accel_lim = cfg_data[Q27_WIDTH-1:0];
          REG_RATE_LIMIT:      rate_lim = cfg_data[Q27_WIDTH-1:0];
          REG_COUNT_LIMIT:     count_lim = cfg_data[COUNT_WIDTH-1:0];
          REG_RESTART_ENABLE:  restart_en = cfg_data[0];
          default: ;
        endcase
      end
      // Compare each result transaction with the oldest prediction
      if (out_valid && out_ready) begin
        if (clamped_due.size() == 0) begin
          mismatches++;
          $display("%0t: result transaction with nothing expected", $time);
        end else begin
          want = clamped_due.pop_front();
          compare_field("clamped_accel_x", want.ax, clamped_accel_x);
          compare_field("clamped_accel_y", want.ay, clamped_accel_y);
          compare_field("clamped_accel_z", want.az, clamped_accel_z);
          compare_field("clamped_rate_x", want.rx, clamped_rate_x);
          compare_field("clamped_rate_y", want.ry, clamped_rate_y);
          compare_field("clamped_rate_z", want.rz, clamped_rate_z);
          compare_field("sample_over_range", field_t'(want.over),
                        field_t'(sample_over_range));
          compare_field("over_range_status", field_t'(want.status),
                        field_t'(over_range_status));
          compare_field("restart_request", field_t'(want.restart),
                        field_t'(restart_request));
          if (restart_request === 1'b1) begin
            restarts_seen++;
          end
        end
      end
      // Predict the result of each sample transaction
      if (in_valid && in_ready) begin
        clamped_due.push_back(clamp_and_count(accel_x, accel_y, accel_z,
                                              rate_x, rate_y, rate_z));
      end
    end
    results_due = clamped_due.size();
  end

endmodule

FILE: test/tb_sensor_over_range_monitor.sv
// ----------------------------------------------------------------------------
// tb_sensor_over_range_monitor: testbench for the six-axis over-range monitor
// Drives samples and register writes with random idling on both channels:
// a directed opening at thresholds, limits and extreme samples, a burst
// with every axis over range that drives the event counter up, then random
// phases under random register settings. Checking is left to
// over_range_checker.
// ----------------------------------------------------------------------------
module tb_sensor_over_range_monitor;
  import sorm_pkg::*;

  localparam int     CYCLE_LIMIT = 200000;
  localparam int     BURST_ITEMS = 100;
  localparam int     RANDOM_PHASES = 9;
  localparam int     PHASE_ITEMS = 110;
  localparam int     IDLE_PERCENT = 23;
  localparam int     SETTLE_CYCLES = 4;
  localparam field_t MOST_POSITIVE = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
  localparam field_t MOST_NEGATIVE = {1'b1, {(FIELD_WIDTH-1){1'b0}}};
  localparam q27_t   Q27_MAX = '1;
  localparam count_t LIMIT_MAX = '1;
  localparam int     FIRST_UNUSED_INDEX = REG_RESTART_ENABLE + 1;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  field_t     accel_x = '0;
  field_t     accel_y = '0;
  field_t     accel_z = '0;
  field_t     rate_x = '0;
  field_t     rate_y = '0;
  field_t     rate_z = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  field_t     clamped_accel_x;
  field_t     clamped_accel_y;
  field_t     clamped_accel_z;
  field_t     clamped_rate_x;
  field_t     clamped_rate_y;
  field_t     clamped_rate_z;
  logic       sample_over_range;
  logic       over_range_status;
  logic       restart_request;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = '0;
  cfg_data_t  cfg_data = '0;

  int mismatches;
  int results_due;
  int restarts_seen;

  // No idling on either side while calm is high
  logic calm = 1'b0;
  int   cycles = 0;
  int   samples_sent = 0;
  int   settings_used = 0;

  // Current settings, used to aim samples at thresholds and limits
  q27_t accel_thr_now = Q27_MAX;
  q27_t rate_thr_now = Q27_MAX;
  q27_t accel_lim_now = Q27_MAX;
  q27_t rate_lim_now = Q27_MAX;

  sensor_over_range_monitor dut (.*);

  over_range_checker checker_i (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one sample, idling first at random; hold until accepted
  task automatic push_sample(input field_t ax, input field_t ay, input field_t az,
                             input field_t rx, input field_t ry, input field_t rz);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= ax;
    accel_y <= ay;
    accel_z <= az;
    rate_x <= rx;
    rate_y <= ry;
    rate_z <= rz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write all six registers with junk in the spare bits; now and then
  // an unmapped index as well
  task automatic apply_setting(input q27_t athr, input q27_t rthr, input q27_t alim,
                               input q27_t rlim, input count_t climit, input logic en);
    write_reg(REG_ACCEL_THRESHOLD, {1'($urandom), athr});
    write_reg(REG_RATE_THRESHOLD, {1'($urandom), rthr});
    write_reg(REG_ACCEL_LIMIT, {1'($urandom), alim});
    write_reg(REG_RATE_LIMIT, {1'($urandom), rlim});
    write_reg(REG_COUNT_LIMIT, {16'($urandom), climit});
    write_reg(REG_RESTART_ENABLE, {31'($urandom), en});
    if ($urandom_range(2) == 0) begin
      write_reg(cfg_index_t'($urandom_range(2**CFG_INDEX_WIDTH-1, FIRST_UNUSED_INDEX)),
                cfg_data_t'($urandom));
    end
    accel_thr_now = athr;
    rate_thr_now = rthr;
    accel_lim_now = alim;
    rate_lim_now = rlim;
    settings_used++;
  endtask

  function automatic q27_t pick_q27();
    case ($urandom_range(4))
      0:       return '0;
      1:       return Q27_MAX;
      2:       return q27_t'($urandom_range(2000));
      3:       return q27_t'($urandom_range(1 << 24));
      default: return q27_t'($urandom);
    endcase
  endfunction

  function automatic count_t pick_count_limit();
    case ($urandom_range(3))
      0:       return '0;
      1:       return LIMIT_MAX;
      default: return count_t'($urandom_range(40));
    endcase
  endfunction

  // At or below threshold when quiet, otherwise aimed at edges or anywhere
  function automatic field_t pick_axis(input q27_t thr, input q27_t lim, input logic quiet);
    field_t v;
    if (quiet) begin
      v = field_t'($urandom_range(thr));
      return $urandom_range(1) ? -v : v;
    end
    case ($urandom_range(11))
      0:       v = '0;
      1:       v = field_t'(thr);
      2:       v = field_t'(thr) + 1;
      3:       v = -field_t'(thr);
      4:       v = -field_t'(thr) - 1;
      5:       v = field_t'(lim);
      6:       v = field_t'(lim) + 1;
      7:       v = -field_t'(lim) - 1;
      8:       v = MOST_NEGATIVE;
      9:       v = MOST_POSITIVE;
      10:      v = field_t'($urandom_range(2000)) - 1000;
      default: v = field_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic random_sample(input logic quiet);
    push_sample(pick_axis(accel_thr_now, accel_lim_now, quiet),
                pick_axis(accel_thr_now, accel_lim_now, quiet),
                pick_axis(accel_thr_now, accel_lim_now, quiet),
                pick_axis(rate_thr_now, rate_lim_now, quiet),
                pick_axis(rate_thr_now, rate_lim_now, quiet),
                pick_axis(rate_thr_now, rate_lim_now, quiet));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: only the most negative sample is over range
    push_sample('0, '0, '0, '0, '0, '0);
    push_sample(MOST_POSITIVE, MOST_POSITIVE, MOST_POSITIVE,
                MOST_POSITIVE, MOST_POSITIVE, MOST_POSITIVE);
    push_sample(MOST_NEGATIVE, MOST_NEGATIVE, MOST_NEGATIVE,
                MOST_NEGATIVE, MOST_NEGATIVE, MOST_NEGATIVE);
    push_sample(MOST_POSITIVE, MOST_NEGATIVE, -1, 1, MOST_NEGATIVE, MOST_POSITIVE);
    settle();

    // Small thresholds, rate clamp at zero, restart when the count passes three
    apply_setting(31'd1000, 31'd2000, 31'd5000, '0, 16'd3, 1'b1);
    push_sample(1000, -1000, 999, 2000, -2000, 0);
    push_sample(1001, 0, 0, 0, 0, 0);
    push_sample(6000, -6000, 5000, 3, -3, 0);
    push_sample(-1001, 0, 0, 0, 2001, 0);
    push_sample(0, 0, -5001, 0, 0, -2001);
    push_sample(MOST_NEGATIVE, MOST_POSITIVE, 0, MOST_NEGATIVE, MOST_POSITIVE, 0);
    push_sample(0, 0, 0, 0, 0, 0);
    push_sample(0, 0, 0, 0, 0, 0);
    push_sample(0, 0, 0, 0, 0, 0);
    settle();

    // Zero thresholds and zero count limit: any nonzero axis restarts
    apply_setting('0, '0, Q27_MAX, Q27_MAX, '0, 1'b1);
    push_sample(1, 0, 0, 0, 0, 0);
    push_sample(0, 0, 0, 0, 0, -1);
    push_sample(0, 0, 0, 0, 0, 0);
    push_sample(0, 0, 0, 0, 0, 0);
    settle();

    // Build the counter up, then probe the top count limits
    apply_setting('0, '0, Q27_MAX, Q27_MAX, LIMIT_MAX, 1'b0);
    for (int i = 0; i < BURST_ITEMS; i++) begin
      push_sample(field_t'($urandom) | 1, field_t'($urandom) | 1, field_t'($urandom) | 1,
                  field_t'($urandom) | 1, field_t'($urandom) | 1, field_t'($urandom) | 1);
    end
    settle();
    apply_setting('0, '0, Q27_MAX, Q27_MAX, LIMIT_MAX, 1'b1);
    push_sample(1, 1, 1, 1, 1, 1);
    push_sample(1, 1, 1, 1, 1, 1);
    settle();
    apply_setting('0, '0, Q27_MAX, Q27_MAX, LIMIT_MAX - 1'b1, 1'b1);
    push_sample(1, 1, 1, 1, 1, 1);
    push_sample(0, 0, 0, 0, 0, 0);
    settle();

    // Random phases under random settings; one phase runs without idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_setting(pick_q27(), pick_q27(), pick_q27(), pick_q27(),
                    pick_count_limit(), 1'($urandom));
      calm = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_sample($urandom_range(99) < 35);
      end
      settle();
      calm = 1'b0;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d samples under %0d register settings, %0d restart pulses checked.",
             samples_sent, settings_used, restarts_seen);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
